// ----- rtl/core/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// cht_pkg
// Shared sizes, codes and state types for the chained hash table unit.
// ----------------------------------------------------------------------------
package cht_pkg;

  // Payload widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 4;

  // Table geometry
  localparam int BUCKETS     = 10;
  localparam int CHAIN_DEPTH = 8;
  localparam int SLOTS       = BUCKETS * CHAIN_DEPTH;

  localparam int BKT_IDX_W = $clog2(BUCKETS);
  localparam int FILL_W    = $clog2(CHAIN_DEPTH + 1);
  localparam int CNT_W     = FILL_W + 1;
  localparam int SLOT_AW   = $clog2(SLOTS);

  // Remainder unit: four key bits per cycle, most significant first
  localparam int HASH_RADIX_W = 4;
  localparam int HASH_STEPS   = (KEY_W + HASH_RADIX_W - 1) / HASH_RADIX_W;
  localparam int HASH_PAD_W   = HASH_STEPS * HASH_RADIX_W;
  localparam int HASH_CNT_W   = $clog2(HASH_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_SCAN,
    S_SHIFT,
    S_REPLY
  } state_e;

endpackage

// ----- rtl/core/cht_req_if.sv -----
// ----------------------------------------------------------------------------
// cht_req_if
// Request channel: operation and key under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cht_req_if;
  import cht_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [KEY_W-1:0]    key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);

endinterface

// ----- rtl/core/cht_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cht_rsp_if
// Response channel: status and bucket index under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cht_rsp_if;
  import cht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, output status, output bucket, input ready);
  modport sink   (input valid, input status, input bucket, output ready);

endinterface

// ----- rtl/core/cht_hash.sv -----
// ----------------------------------------------------------------------------
// cht_hash
// Iterative key modulo BUCKETS: a few bits of the key per cycle, each bit
// folded in with one shift and one conditional subtract.
// ----------------------------------------------------------------------------
module cht_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cht_pkg::KEY_W-1:0]     key_i,
  output logic                          done_o,
  output logic [cht_pkg::BKT_IDX_W-1:0] bucket_o
);
  import cht_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [HASH_CNT_W-1:0] cnt_q, cnt_d;
  logic [HASH_PAD_W-1:0] shift_q, shift_d;
  logic [BKT_IDX_W-1:0]  rem_q, rem_d;
  logic [BKT_IDX_W-1:0]  rem_step;

  // Fold HASH_RADIX_W bits into the running remainder
  always_comb begin
    logic [BKT_IDX_W:0] t;
    rem_step = rem_q;
    for (int k = 0; k < HASH_RADIX_W; k++) begin
      t = {rem_step, shift_q[HASH_PAD_W-1-k]};
      if (t >= (BKT_IDX_W+1)'(BUCKETS)) begin
        t = t - (BKT_IDX_W+1)'(BUCKETS);
      end
      rem_step = t[BKT_IDX_W-1:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = HASH_CNT_W'(HASH_STEPS - 1);
      shift_d = HASH_PAD_W'(key_i);
      rem_d   = '0;
    end else if (busy_q) begin
      rem_d   = rem_step;
      shift_d = shift_q << HASH_RADIX_W;
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ----- rtl/core/chained_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// Hash table of keys in fixed-depth buckets: insert, search and delete.
// ----------------------------------------------------------------------------
// One request is handled at a time. The bucket is key modulo BUCKETS, found
// by a remainder unit that takes four key bits per cycle. The keys live in a
// single-port-read, single-port-write slot memory with registered read data,
// so a search or delete compares one slot per cycle and a delete moves one
// later entry down per cycle. The scan stops at the match and the move-down
// covers only the entries after it. A new request is taken while a finished
// response still waits in the output register. The table is empty after
// reset; no clearing pass is needed since only slots below each bucket's
// fill count are ever read.
module chained_hash_table_unit (
  input  logic clk_i,
  input  logic rst_ni,
  cht_req_if.sink   req_i,
  cht_rsp_if.source rsp_o
);
  import cht_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [BKT_IDX_W-1:0] bkt_q, bkt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  status_e              status_q, status_d;

  logic                 rsp_valid_q, rsp_valid_d;
  status_e              rsp_status_q, rsp_status_d;
  logic [BUCKET_W-1:0]  rsp_bucket_q, rsp_bucket_d;

  logic [FILL_W-1:0]    fill_mem_q [BUCKETS];
  logic                 fill_we;
  logic [FILL_W-1:0]    fill_wdata;

  logic [KEY_W-1:0]     slot_mem [SLOTS];
  logic [KEY_W-1:0]     rd_data_q;
  logic                 rd_en, wr_en;
  logic [SLOT_AW-1:0]   rd_addr, wr_addr;
  logic [KEY_W-1:0]     wr_data;

  logic                 hash_start, hash_done;
  logic [BKT_IDX_W-1:0] hash_bucket;

  logic [FILL_W-1:0]    fill_cur;
  logic [CNT_W-1:0]     fill_ext;
  logic [CNT_W-1:0]     idx_nxt;
  logic [CNT_W-1:0]     idx_nxt2;
  logic                 key_match;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [BKT_IDX_W-1:0] b,
                                                   input logic [CNT_W-1:0]     i);
    return SLOT_AW'(b) * SLOT_AW'(CHAIN_DEPTH) + SLOT_AW'(i);
  endfunction

  cht_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (req_i.key),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  assign fill_cur  = fill_mem_q[bkt_q];
  assign fill_ext  = CNT_W'(fill_q);
  assign idx_nxt   = idx_q + CNT_W'(1);
  assign idx_nxt2  = idx_q + CNT_W'(2);
  assign key_match = (rd_data_q == key_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    bkt_d        = bkt_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    status_d     = status_q;
    rsp_status_d = rsp_status_q;
    rsp_bucket_d = rsp_bucket_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    req_i.ready  = 1'b0;
    hash_start   = 1'b0;
    fill_we      = 1'b0;
    fill_wdata   = fill_q;
    rd_en        = 1'b0;
    rd_addr      = slot_addr(bkt_q, idx_q);
    wr_en        = 1'b0;
    wr_addr      = slot_addr(bkt_q, idx_q);
    wr_data      = key_q;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d       = op_e'(req_i.operation);
          key_d      = req_i.key;
          hash_start = 1'b1;
          state_d    = S_HASH;
        end
      end

      S_HASH: begin
        if (hash_done) begin
          bkt_d   = hash_bucket;
          state_d = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        fill_d = fill_cur;
        idx_d  = '0;
        case (op_q)
          OP_INSERT: begin
            if (fill_cur == FILL_W'(CHAIN_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = slot_addr(bkt_q, CNT_W'(fill_cur));
              fill_we    = 1'b1;
              fill_wdata = fill_cur + FILL_W'(1);
              status_d   = ST_INSERTED;
            end
            state_d = S_REPLY;
          end
          OP_SEARCH, OP_DELETE: begin
            if (fill_cur == '0) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_REPLY;
            end else begin
              rd_en   = 1'b1;
              rd_addr = slot_addr(bkt_q, '0);
              state_d = S_SCAN;
            end
          end
          default: begin
            status_d = ST_NOT_FOUND;
            state_d  = S_REPLY;
          end
        endcase
      end

      // rd_data_q holds slot idx_q; prefetch the next slot
      S_SCAN: begin
        if (idx_nxt < fill_ext) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(bkt_q, idx_nxt);
        end
        if (key_match) begin
          if (op_q == OP_SEARCH) begin
            status_d = ST_FOUND;
            state_d  = S_REPLY;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (idx_nxt == fill_ext) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_REPLY;
        end else begin
          idx_d = idx_nxt;
        end
      end

      // rd_data_q holds slot idx_q + 1; move it down one place
      S_SHIFT: begin
        if (idx_nxt < fill_ext) begin
          wr_en   = 1'b1;
          wr_addr = slot_addr(bkt_q, idx_q);
          wr_data = rd_data_q;
          if (idx_nxt2 < fill_ext) begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(bkt_q, idx_nxt2);
          end
          idx_d = idx_nxt;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = fill_q - FILL_W'(1);
          status_d   = ST_DELETED;
          state_d    = S_REPLY;
        end
      end

      // Hold until the output register is free
      S_REPLY: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_bucket_d = BUCKET_W'(bkt_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        fill_mem_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (fill_we) begin
        fill_mem_q[bkt_q] <= fill_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    bkt_q        <= bkt_d;
    idx_q        <= idx_d;
    fill_q       <= fill_d;
    status_q     <= status_d;
    rsp_status_q <= rsp_status_d;
    rsp_bucket_q <= rsp_bucket_d;
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem[rd_addr];
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.bucket = rsp_bucket_q;

endmodule

// ----- tb/sv/cht_reply_checker.sv -----
// ----------------------------------------------------------------------------
// cht_reply_checker
// Watches both channels of the hash table unit. Every request word accepted
// is applied to a shadow table of fixed-depth buckets to work out its reply.
// Every reply word accepted is compared with the oldest reply still owed.
// ----------------------------------------------------------------------------
module cht_reply_checker
  import cht_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [OP_W-1:0]     req_operation_i,
  input  logic [KEY_W-1:0]    req_key_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  logic [STATUS_W-1:0] rsp_status_i,
  input  logic [BUCKET_W-1:0] rsp_bucket_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  status_tally_o [2**STATUS_W]
);

  typedef struct packed {
    status_e             status;
    logic [BUCKET_W-1:0] bucket;
  } reply_t;

  logic [KEY_W-1:0] chain_keys [BUCKETS][CHAIN_DEPTH];
  int               chain_fill [BUCKETS];
  reply_t           owed_replies [$];

  // Apply one request to the shadow table and return the reply it earns.
  function automatic reply_t hash_table_apply(input logic [OP_W-1:0]  op,
                                              input logic [KEY_W-1:0] key);
    int     bkt;
    int     fill;
    int     hit;
    reply_t reply;
    bkt          = int'(key % BUCKETS);
    fill         = chain_fill[bkt];
    reply.status = ST_NOT_FOUND;
    reply.bucket = BUCKET_W'(bkt);
    hit          = fill;
    for (int i = 0; i < fill; i++) begin
      if (hit == fill && chain_keys[bkt][i] == key) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (fill >= CHAIN_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          chain_keys[bkt][fill] = key;
          chain_fill[bkt]       = fill + 1;
          reply.status          = ST_INSERTED;
        end
      end
      OP_SEARCH: begin
        if (hit < fill) reply.status = ST_FOUND;
      end
      OP_DELETE: begin
        if (hit < fill) begin
          // close the gap, keeping the order of later entries
          for (int i = hit; i + 1 < fill; i++) chain_keys[bkt][i] = chain_keys[bkt][i + 1];
          chain_fill[bkt] = fill - 1;
          reply.status    = ST_DELETED;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) chain_fill[b] = 0;
      owed_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
      for (int s = 0; s < 2**STATUS_W; s++) status_tally_o[s] = 0;
    end else begin
      // check the reply first: a request taken in this cycle cannot own it
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_replies.size() == 0) begin
          $error("reply word with no request outstanding: status %0d, bucket %0d",
                 rsp_status_i, rsp_bucket_i);
          fail_count_o++;
        end else begin
          want = owed_replies.pop_front();
          status_tally_o[want.status]++;
          if (rsp_status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status_i);
            fail_count_o++;
          end
          if (rsp_bucket_i !== want.bucket) begin
            $error("bucket mismatch: expected %0d, actual %0d", want.bucket, rsp_bucket_i);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        owed_replies.push_back(hash_table_apply(req_operation_i, req_key_i));
      end
      pending_o = owed_replies.size();
    end
  end

endmodule

// ----- tb/sv/tb_chained_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_chained_hash_table_unit
// Drives insert, search, delete and unused-operation requests into the hash
// table unit: a directed pass over empty, duplicate, full and missing-key
// cases, then random requests over a small key pool in four phases; three
// add sender idling or receiver stalls. A side checker predicts every reply.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_unit;
  import cht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1200;
  localparam int PHASES       = 4;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int TAIL_CYCLES  = 60;
  localparam int KEY_POOL_N   = 20;
  localparam int DIRECTED_N   = 25;

  localparam int PHASE_IDLE  [PHASES] = '{0, 78, 0, 26};
  localparam int PHASE_STALL [PHASES] = '{0, 0, 78, 26};

  localparam logic [OP_W-1:0] DIRECTED_OPS [DIRECTED_N] = '{
    OP_SEARCH, OP_DELETE, OP_INSERT, OP_INSERT, OP_SEARCH,
    OP_SEARCH, OP_UNUSED, OP_UNUSED, OP_INSERT, OP_INSERT,
    OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
    OP_INSERT, OP_INSERT, OP_SEARCH, OP_DELETE, OP_SEARCH,
    OP_DELETE, OP_DELETE, OP_DELETE, OP_INSERT, OP_DELETE
  };
  localparam logic [KEY_W-1:0] DIRECTED_KEYS [DIRECTED_N] = '{
    31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0,
    31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd3, 31'd13,
    31'd23, 31'd33, 31'd43, 31'd53, 31'd63,
    31'd13, 31'd73, 31'd73, 31'd13, 31'd13,
    31'd13, 31'd13, 31'd3, 31'd73, 31'h7FFF_FFFF
  };

  logic clk_i;
  logic rst_ni;

  cht_req_if req_if ();
  cht_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int status_tally [2**STATUS_W];
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycle_count    = 0;
  int words_sent     = 0;

  logic [KEY_W-1:0] key_pool [KEY_POOL_N];

  chained_hash_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cht_reply_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_operation_i (req_if.operation),
    .req_key_i       (req_if.key),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_status_i    (rsp_if.status),
    .rsp_bucket_i    (rsp_if.bucket),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .status_tally_o  (status_tally)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [KEY_W-1:0] random_key();
    // mix short keys with keys that use the full width
    if ($urandom_range(1)) return KEY_W'($urandom_range(9) + 10 * $urandom_range(30));
    return KEY_W'($urandom());
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 42) return OP_INSERT;
    if (r < 67) return OP_SEARCH;
    if (r < 95) return OP_DELETE;
    return OP_UNUSED;
  endfunction

  // Mostly reuse pooled keys so that searches hit, deletes find and buckets fill.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if ($urandom_range(99) < 4) key_pool[$urandom_range(KEY_POOL_N - 1)] = random_key();
    if (r < 60) return key_pool[$urandom_range(KEY_POOL_N - 1)];
    if (r < 85) return KEY_W'($urandom_range(9) + 10 * $urandom_range(40));
    return KEY_W'($urandom());
  endfunction

  // Enter at a falling edge; leave at the falling edge after the word is taken,
  // with valid still high so a back-to-back word keeps it up.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= key;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold off new words until every owed reply is back.
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_INSERT;
    req_if.key       = '0;
    rsp_if.ready     = 1'b0;
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = random_key();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) send_word(DIRECTED_OPS[i], DIRECTED_KEYS[i]);
    drain_replies();

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct   = PHASE_IDLE[ph];
      sink_stall_pct = PHASE_STALL[ph];
      repeat (RANDOM_WORDS / PHASES) send_word(pick_op(), pick_key());
      drain_replies();
    end

    sink_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d request words over %0d idle/stall phases after a directed pass.",
             words_sent, PHASES);
    $display("Replies: %0d inserted, %0d found, %0d not found, %0d deleted, %0d bucket full.",
             status_tally[ST_INSERTED], status_tally[ST_FOUND], status_tally[ST_NOT_FOUND],
             status_tally[ST_DELETED], status_tally[ST_FULL]);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- chained_hash_table_unit.f -----
rtl/core/cht_pkg.sv
rtl/core/cht_req_if.sv
rtl/core/cht_rsp_if.sv
rtl/core/cht_hash.sv
rtl/core/chained_hash_table_unit.sv
tb/sv/cht_reply_checker.sv
tb/sv/tb_chained_hash_table_unit.sv
